// ===== rtl/core/bbc_pkg.sv =====
// ============================================================================
// bbc_pkg
// Shared widths, register codes, datapath command types and saturation
// helpers for the Butterworth biquad cascade.
// ============================================================================
package bbc_pkg;

    // Field and word widths
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 20;
    localparam int WORD_W       = 40;  // delay words and inter-section value, Q31.8
    localparam int SUM_W        = WORD_W + 2;  // w + 2*d1 + d2
    localparam int CHUNK_W      = SUM_W / 2;   // operand split for the shared multiplier
    localparam int PROD_W       = COEF_W + CHUNK_W + 1;
    localparam int ACC_W        = 62;
    localparam int COEF_FRAC    = 18;
    localparam int DATA_FRAC    = 8;

    // Section bookkeeping
    localparam int MAX_SECTIONS = 2;
    localparam int SEC_W        = 1;
    localparam int ACT_W        = 2;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = COEF_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE   = 3'd0,
        REG_GAIN_S0  = 3'd1,
        REG_FB1_S0   = 3'd2,
        REG_FB2_S0   = 3'd3,
        REG_GAIN_S1  = 3'd4,
        REG_FB1_S1   = 3'd5,
        REG_FB2_S1   = 3'd6
    } t_cfg_idx;

    // Multiplier source selects
    typedef enum logic [1:0] {
        CF_FB1,
        CF_FB2,
        CF_GAIN
    } t_coef_sel;

    typedef enum logic [1:0] {
        OP_D1,
        OP_D2,
        OP_SUM
    } t_opnd_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic             load_x;     // take the input sample as x
        logic             acc_init;   // acc <= x << COEF_FRAC
        logic             acc_clr;    // acc <= 0
        logic             mul_en;     // register one partial product
        t_coef_sel        coef_sel;
        t_opnd_sel        opnd_sel;
        logic             mul_hi;     // upper operand chunk
        logic             acc_add;    // acc += last partial product
        logic             w_latch;    // w <= sat(round(acc))
        logic             sum_latch;  // sum <= w + 2*d1 + d2
        logic             x_latch;    // x <= sat(round(acc)), shift delay words
        logic             out_latch;  // output register <= sat16(round(x))
        logic [SEC_W-1:0] sec;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [ACT_W-1:0] n_sections;  // active count, limited to MAX_SECTIONS
    } t_dp_stat;

    // Clamp a wide signed value to a signed 40-bit word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [WORD_W-1:0] res;
        if ((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1])) begin
            res = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Clamp a shifted word to a signed 16-bit sample
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WORD_W:0] v
    );
        logic signed [SAMPLE_W-1:0] res;
        if ((&v[WORD_W:SAMPLE_W-1]) || !(|v[WORD_W:SAMPLE_W-1])) begin
            res = v[SAMPLE_W-1:0];
        end else if (v[WORD_W]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/bbc_in_if.sv =====
// ============================================================================
// bbc_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ============================================================================
interface bbc_in_if;
    import bbc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/bbc_out_if.sv =====
// ============================================================================
// bbc_out_if
// Output sample channel: valid/ready handshake with one signed sample.
// ============================================================================
interface bbc_out_if;
    import bbc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/bbc_ctrl.sv =====
// ============================================================================
// bbc_ctrl
// Sequencer for the biquad cascade: steps each active section through the
// shared multiplier schedule and manages both handshakes.
// ============================================================================
module bbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bbc_pkg::t_dp_stat  i_stat,
    output bbc_pkg::t_dp_cmd   o_cmd
);
    import bbc_pkg::*;

    localparam int STEP_W = 4;

    // Per-section schedule
    localparam logic [STEP_W-1:0] STEP_FB1_LO = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FB1_HI = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FB2_LO = 4'd2;
    localparam logic [STEP_W-1:0] STEP_FB2_HI = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FB_ADD = 4'd4;
    localparam logic [STEP_W-1:0] STEP_W_SAT  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUM    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_G_LO   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_G_HI   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_G_ADD  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_X_SAT  = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [SEC_W-1:0]  r_sec;
    logic              r_out_valid;

    logic in_xfer;
    logic out_free;
    logic last_sec;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign last_sec    = (ACT_W'(r_sec) + ACT_W'(1)) >= i_stat.n_sections;

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.coef_sel  = CF_FB1;
        o_cmd.opnd_sel  = OP_D1;
        o_cmd.sec       = r_sec;
        o_cmd.load_x    = in_xfer;
        o_cmd.out_latch = (r_state == ST_FIN) && out_free;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                STEP_FB1_LO: begin
                    o_cmd.acc_init = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                end
                STEP_FB1_HI: begin
                    o_cmd.acc_add  = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_hi   = 1'b1;
                end
                STEP_FB2_LO: begin
                    o_cmd.acc_add  = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.coef_sel = CF_FB2;
                    o_cmd.opnd_sel = OP_D2;
                end
                STEP_FB2_HI: begin
                    o_cmd.acc_add  = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_hi   = 1'b1;
                    o_cmd.coef_sel = CF_FB2;
                    o_cmd.opnd_sel = OP_D2;
                end
                STEP_FB_ADD: o_cmd.acc_add = 1'b1;
                STEP_W_SAT:  o_cmd.w_latch = 1'b1;
                STEP_SUM: begin
                    o_cmd.sum_latch = 1'b1;
                    o_cmd.acc_clr   = 1'b1;
                end
                STEP_G_LO: begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.coef_sel = CF_GAIN;
                    o_cmd.opnd_sel = OP_SUM;
                end
                STEP_G_HI: begin
                    o_cmd.acc_add  = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_hi   = 1'b1;
                    o_cmd.coef_sel = CF_GAIN;
                    o_cmd.opnd_sel = OP_SUM;
                end
                STEP_G_ADD:  o_cmd.acc_add = 1'b1;
                STEP_X_SAT:  o_cmd.x_latch = 1'b1;
                default: ;
            endcase
        end
    end

    // State, step and section counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the final state a taken output is replaced by the new one
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_step  <= STEP_FB1_LO;
                        r_sec   <= '0;
                        r_state <= (i_stat.n_sections == '0) ? ST_FIN : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_X_SAT) begin
                        r_step <= STEP_FB1_LO;
                        if (last_sec) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_sec <= r_sec + SEC_W'(1);
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/bbc_dp.sv =====
// ============================================================================
// bbc_dp
// Datapath of the biquad cascade: coefficient registers, delay words, one
// shared 20x22 multiplier, a 62-bit accumulator and the output register.
// ============================================================================
module bbc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bbc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [bbc_pkg::SAMPLE_W-1:0] i_sample,
    input  bbc_pkg::t_dp_cmd                    i_cmd,
    output bbc_pkg::t_dp_stat                   o_stat,
    output logic signed [bbc_pkg::SAMPLE_W-1:0] o_sample
);
    import bbc_pkg::*;

    // Configuration
    logic [ACT_W-1:0]         r_active;
    logic signed [COEF_W-1:0] r_gain [MAX_SECTIONS];
    logic signed [COEF_W-1:0] r_fb1  [MAX_SECTIONS];
    logic signed [COEF_W-1:0] r_fb2  [MAX_SECTIONS];

    // Filter state and working registers
    logic signed [WORD_W-1:0]   r_d1 [MAX_SECTIONS];
    logic signed [WORD_W-1:0]   r_d2 [MAX_SECTIONS];
    logic signed [WORD_W-1:0]   r_x;
    logic signed [WORD_W-1:0]   r_w;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_hi;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [COEF_W-1:0]   coef;
    logic signed [SUM_W-1:0]    opnd;
    logic signed [CHUNK_W:0]    chunk;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [WORD_W-1:0]   acc_sat;
    logic signed [WORD_W-1:0]   d1;
    logic signed [WORD_W-1:0]   d2;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [WORD_W:0]     x_rnd;

    assign d1 = r_d1[i_cmd.sec];
    assign d2 = r_d2[i_cmd.sec];

    // Active count, limited to the sections built
    assign o_stat.n_sections = (r_active > ACT_W'(MAX_SECTIONS)) ? ACT_W'(MAX_SECTIONS)
                                                                : r_active;

    // Multiplier operand selection
    always_comb begin
        unique case (i_cmd.coef_sel)
            CF_FB1:  coef = r_fb1[i_cmd.sec];
            CF_FB2:  coef = r_fb2[i_cmd.sec];
            CF_GAIN: coef = r_gain[i_cmd.sec];
            default: coef = '0;
        endcase
        unique case (i_cmd.opnd_sel)
            OP_D1:   opnd = {{(SUM_W-WORD_W){d1[WORD_W-1]}}, d1};
            OP_D2:   opnd = {{(SUM_W-WORD_W){d2[WORD_W-1]}}, d2};
            OP_SUM:  opnd = r_sum;
            default: opnd = '0;
        endcase
        if (i_cmd.mul_hi) begin
            chunk = {opnd[SUM_W-1], opnd[SUM_W-1:CHUNK_W]};
        end else begin
            chunk = {1'b0, opnd[CHUNK_W-1:0]};
        end
    end

    assign n_prod = coef * chunk;

    // Partial product aligned to the accumulator
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (r_prod_hi) begin
            prod_ext = prod_ext <<< CHUNK_W;
        end
    end

    // Round half up, drop coefficient fraction, clamp to a word
    assign acc_rnd = (r_acc + (ACC_W'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    assign acc_sat = sat_word(acc_rnd);

    assign n_sum = {{(SUM_W-WORD_W){r_w[WORD_W-1]}}, r_w}
                 + {d1[WORD_W-1], d1, 1'b0}
                 + {{(SUM_W-WORD_W){d2[WORD_W-1]}}, d2};

    assign x_rnd = ($signed({r_x[WORD_W-1], r_x}) + (WORD_W+1)'(1 <<< (DATA_FRAC - 1)))
                   >>> DATA_FRAC;

    // Configuration registers and delay words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACT_W'(MAX_SECTIONS);
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_gain[i] <= '0;
                r_fb1[i]  <= '0;
                r_fb2[i]  <= '0;
                r_d1[i]   <= '0;
                r_d2[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_ACTIVE:  r_active  <= i_cfg_data[ACT_W-1:0];
                    REG_GAIN_S0: r_gain[0] <= i_cfg_data;
                    REG_FB1_S0:  r_fb1[0]  <= i_cfg_data;
                    REG_FB2_S0:  r_fb2[0]  <= i_cfg_data;
                    REG_GAIN_S1: r_gain[1] <= i_cfg_data;
                    REG_FB1_S1:  r_fb1[1]  <= i_cfg_data;
                    REG_FB2_S1:  r_fb2[1]  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.x_latch) begin
                r_d2[i_cmd.sec] <= d1;
                r_d1[i_cmd.sec] <= r_w;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= n_prod;
            r_prod_hi <= i_cmd.mul_hi;
        end
        if (i_cmd.acc_init) begin
            r_acc <= {{(ACC_W-WORD_W-COEF_FRAC){r_x[WORD_W-1]}}, r_x, {COEF_FRAC{1'b0}}};
        end else if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
        if (i_cmd.load_x) begin
            r_x <= {{(WORD_W-SAMPLE_W-DATA_FRAC){i_sample[SAMPLE_W-1]}}, i_sample,
                    {DATA_FRAC{1'b0}}};
        end else if (i_cmd.x_latch) begin
            r_x <= acc_sat;
        end
        if (i_cmd.w_latch) begin
            r_w <= acc_sat;
        end
        if (i_cmd.sum_latch) begin
            r_sum <= n_sum;
        end
        if (i_cmd.out_latch) begin
            r_out <= sat_sample(x_rnd);
        end
    end

    assign o_sample = r_out;

endmodule

// ===== rtl/core/butterworth_biquad_cascade_unit.sv =====
// Each input transfer runs through the N active sections (0..2) before its result reaches the output register.
// The shared 20x22 multiplier takes six partial products per section, plus rounding, sum and saturation
//   steps; a new sample is accepted only after the previous result is latched into the output register.
// The output register holds a result while the next sample is accepted.
// Reset (synchronous, active low): two sections active, all coefficients and delay words zero.
// ============================================================================
// butterworth_biquad_cascade_unit
// Cascade of up to two direct-form-II low-pass biquad sections on 16-bit samples.
// ============================================================================
module butterworth_biquad_cascade_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bbc_in_if.sink                         i_in,
    bbc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bbc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage
    bbc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_in.sample_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_sample   (o_out.sample_out)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the Butterworth biquad cascade. A directed pass
// covers silence after reset, pass-through with no sections, coefficient
// extremes that drive the delay words and output into saturation, an
// over-range section count and a write to an unmapped register. Random
// phases then reprogram the filter and stream noise, random walks and
// low-level signals, mostly with random stalls on both channels. Expected
// samples come from a bit-accurate fixed-point model of the cascade.
// ============================================================================
module tb_top;
    import bbc_pkg::*;

    localparam int  RAND_PHASES    = 22;
    localparam int  PHASE_ITEMS    = 50;
    localparam int  SETTLE_CYCLES  = 32;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  IDLE_PCT       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] EXTREMES [5] =
        '{SAMPLE_MIN, SAMPLE_MAX, 16'sd0, 16'sd1, -16'sd1};

    localparam int COEF_MAX = 524287;
    localparam int COEF_MIN = -524288;

    localparam longint WORD_HI = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint WORD_LO = -(longint'(1) <<< (WORD_W - 1));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bbc_in_if  in_if ();
    bbc_out_if out_if ();

    butterworth_biquad_cascade_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Model copy of configuration and filter state
    logic [ACT_W-1:0]         sections_cfg;
    logic signed [COEF_W-1:0] gain_q [MAX_SECTIONS];
    logic signed [COEF_W-1:0] fb1_q  [MAX_SECTIONS];
    logic signed [COEF_W-1:0] fb2_q  [MAX_SECTIONS];
    logic signed [WORD_W-1:0] dly1   [MAX_SECTIONS];
    logic signed [WORD_W-1:0] dly2   [MAX_SECTIONS];

    logic signed [SAMPLE_W-1:0] input_samples [$];
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    int error_count = 0;
    int stall_cycles = 0;
    bit no_gaps = 1'b0;

    // Round half up, then arithmetic shift
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Runs one sample through the active sections and updates their delay words
    function automatic logic signed [SAMPLE_W-1:0] cascade_filter(
        input logic signed [SAMPLE_W-1:0] s
    );
        longint x, acc, w, d1, d2, total;
        int     n, k;
        x = longint'(s) <<< DATA_FRAC;
        n = (sections_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_cfg);
        for (k = 0; k < n; k++) begin
            d1    = longint'(dly1[k]);
            d2    = longint'(dly2[k]);
            acc   = longint'(fb1_q[k]) * d1 + longint'(fb2_q[k]) * d2
                  + (x <<< COEF_FRAC);
            w     = clip(round_shift(acc, COEF_FRAC), WORD_LO, WORD_HI);
            total = w + 2 * d1 + d2;
            x     = clip(round_shift(longint'(gain_q[k]) * total, COEF_FRAC),
                         WORD_LO, WORD_HI);
            dly2[k] = d1[WORD_W-1:0];
            dly1[k] = w[WORD_W-1:0];
        end
        x = clip(round_shift(x, DATA_FRAC), -32768, 32767);
        return x[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(19))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One register write per clock; the caller lowers the enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ACTIVE:  sections_cfg = data[ACT_W-1:0];
            REG_GAIN_S0: gain_q[0] = data;
            REG_FB1_S0:  fb1_q[0] = data;
            REG_FB2_S0:  fb2_q[0] = data;
            REG_GAIN_S1: gain_q[1] = data;
            REG_FB1_S1:  fb1_q[1] = data;
            REG_FB2_S1:  fb2_q[1] = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_section(input int k, input int g, input int f1, input int f2);
        write_reg(k ? REG_GAIN_S1 : REG_GAIN_S0, g[CFG_DATA_W-1:0]);
        write_reg(k ? REG_FB1_S1 : REG_FB1_S0, f1[CFG_DATA_W-1:0]);
        write_reg(k ? REG_FB2_S1 : REG_FB2_S0, f2[CFG_DATA_W-1:0]);
    endtask

    // Mostly stable pole pairs, some raw bit patterns and corner values
    task automatic random_section(input int k);
        int g, f1, f2, lim;
        case ($urandom_range(9))
            0: begin
                g  = $urandom;
                f1 = $urandom;
                f2 = $urandom;
            end
            1: begin
                g  = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                f1 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                f2 = $urandom_range(1) ? COEF_MAX : COEF_MIN;
            end
            default: begin
                lim = $urandom_range(250000);
                f2  = -lim;
                lim = int'(2.0 * $sqrt(real'(lim) * 262144.0)) - 1;
                if (lim < 1) lim = 1;
                f1  = int'($urandom_range(2 * lim)) - lim;
                g   = $urandom_range(60000);
                if ($urandom_range(7) == 0) g = -g;
            end
        endcase
        program_section(k, g, f1, f2);
    endtask

    // Wait until every sample is through, then let the pipeline go quiet
    task automatic drain_and_settle();
        while (input_samples.size() != 0 || in_if.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: predicts each sample at its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid)
                expected_samples.push_back(cascade_filter(in_if.sample_in));
            if (input_samples.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                in_if.valid     <= 1'b1;
                in_if.sample_in <= input_samples.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Output monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample_out %0d", $time, out_if.sample_out);
                    error_count++;
                end else if (out_if.sample_out !== expected_samples[0]) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, expected_samples[0], out_if.sample_out);
                    error_count++;
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
            out_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int ph, j, k, sel, walk, style;
        logic [CFG_DATA_W-1:0] act_word;

        in_if.valid     = 1'b0;
        in_if.sample_in = '0;
        out_if.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        sections_cfg    = ACT_W'(MAX_SECTIONS);
        for (k = 0; k < MAX_SECTIONS; k++) begin
            gain_q[k] = '0;
            fb1_q[k]  = '0;
            fb2_q[k]  = '0;
            dly1[k]   = '0;
            dly2[k]   = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: silence
        foreach (EXTREMES[j]) input_samples.push_back(EXTREMES[j]);
        drain_and_settle();

        // No sections: samples pass straight through; upper data bits ignored
        write_reg(REG_ACTIVE, 20'hFFFFC);
        i_cfg_we <= 1'b0;
        foreach (EXTREMES[j]) input_samples.push_back(EXTREMES[j]);
        input_samples.push_back(16'sh5555);
        input_samples.push_back(16'shAAAA);
        drain_and_settle();

        // One section at coefficient extremes: delay words and output saturate
        write_reg(REG_ACTIVE, 20'd1);
        program_section(0, COEF_MAX, COEF_MIN, COEF_MAX);
        i_cfg_we <= 1'b0;
        for (j = 0; j < 4; j++) input_samples.push_back(SAMPLE_MAX);
        for (j = 0; j < 3; j++) input_samples.push_back(SAMPLE_MIN);
        drain_and_settle();

        // Count above the maximum acts as two; unmapped register ignored
        write_reg(REG_ACTIVE, 20'd3);
        program_section(0, 17695, 299610, -108213);
        program_section(1, COEF_MIN, COEF_MAX, COEF_MIN);
        write_reg(REG_UNUSED, 20'hFFFFF);
        i_cfg_we <= 1'b0;
        input_samples.push_back(SAMPLE_MAX);
        input_samples.push_back(SAMPLE_MIN);
        input_samples.push_back(16'sd1000);
        input_samples.push_back(-16'sd1000);
        input_samples.push_back(16'sd0);
        input_samples.push_back(16'sd0);
        drain_and_settle();

        // Random phases: new filter settings, then a burst of samples
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            no_gaps = (ph >= 8 && ph < 12);
            sel = $urandom_range(9);
            act_word = CFG_DATA_W'($urandom);
            act_word[ACT_W-1:0] = (sel == 0) ? 2'd0 : (sel == 1) ? 2'd3 :
                                  (sel < 5) ? 2'd1 : 2'd2;
            write_reg(REG_ACTIVE, act_word);
            for (k = 0; k < MAX_SECTIONS; k++)
                if ($urandom_range(4) != 0) random_section(k);
            if ($urandom_range(5) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            i_cfg_we <= 1'b0;

            style = $urandom_range(2);
            walk  = 0;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                case (style)
                    0: input_samples.push_back(random_sample());
                    1: begin
                        walk = walk + int'($urandom_range(6000)) - 3000;
                        if (walk > 32767)  walk = 32767;
                        if (walk < -32768) walk = -32768;
                        input_samples.push_back(walk[SAMPLE_W-1:0]);
                    end
                    default: begin
                        if ($urandom_range(15) == 0) begin
                            input_samples.push_back(random_sample());
                        end else begin
                            walk = int'($urandom_range(600)) - 300;
                            input_samples.push_back(walk[SAMPLE_W-1:0]);
                        end
                    end
                endcase
            end
            drain_and_settle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bbc_pkg.sv
rtl/core/bbc_in_if.sv
rtl/core/bbc_out_if.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_dp.sv
rtl/core/butterworth_biquad_cascade_unit.sv
tb/sv/tb_top.sv
